FILE: hw/rtl/sorted_key_value_table_macros.svh
// ---------------------------------------------------------------------------
// sorted_key_value_table assertion macros
// Shorthand for clocked, reset-qualified properties used by the table.
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_TABLE_MACROS_SVH
`define SORTED_KEY_VALUE_TABLE_MACROS_SVH

// same-cycle implication
`define SKVT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("skvt: same-cycle check failed");

// next-cycle implication
`define SKVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("skvt: next-cycle check failed");

`endif

FILE: hw/rtl/skvt_pkg.sv
// ---------------------------------------------------------------------------
// skvt_pkg
// Sizes, codes and payload types of the sorted key/value table.
// ---------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;

    // operation codes
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_FIND   = 2'd1;
    localparam logic [1:0] FUNC_UPDATE = 2'd2;

    // result status codes
    localparam logic [2:0] STATUS_DONE   = 3'd0;
    localparam logic [2:0] STATUS_REJECT = 3'd1;
    localparam logic [2:0] STATUS_DUP    = 3'd2;
    localparam logic [2:0] STATUS_MISS   = 3'd3;
    localparam logic [2:0] STATUS_FULL   = 3'd4;

    typedef struct packed {
        logic [1:0]         func;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic               overwrite_if_present;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic               hit;
        logic [VALUE_W-1:0] found_value;
    } t_res;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_entry;

endpackage

`default_nettype wire

FILE: hw/rtl/sorted_key_value_table.sv
// ---------------------------------------------------------------------------
// sorted_key_value_table
// Bounded key/value map held in ascending key order in one entry RAM.
// ---------------------------------------------------------------------------
//  channel   signals                            direction
//  request   i_in_valid / o_in_stall / i_in_req  in
//  result    o_out_valid / i_out_stall / o_out_res out
//
//  A request with a zero key, a zero insert value or an unused code goes
//  straight from idle to the response state. Any other scans the table:
//  one RAM read per entry, the scan loop issuing the next read while the
//  current entry is compared and, for an insert, written back one place
//  higher. One request is in flight at a time. Reset empties the table at
//  once. A stalled result waits in the output register while the next
//  request runs.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sorted_key_value_table_macros.svh"

module sorted_key_value_table
    import skvt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_req i_in_req,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_res      o_out_res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_RESP = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_shift, n_shift;
    t_entry             r_carry, n_carry;
    t_req               r_req, n_req;
    t_res               r_res, n_res;
    t_res               r_out, n_out;
    logic               r_out_valid, n_out_valid;

    t_entry             r_mem [CAPACITY];
    t_entry             r_rd_data;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;

    logic [CNT_W-1:0]   idx_inc;
    logic               at_end;
    logic               full;

    assign idx_inc = r_idx + CNT_W'(1);
    assign at_end  = (r_idx == r_count);
    assign full    = (r_count == CNT_W'(CAPACITY));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_shift     = r_shift;
        n_carry     = r_carry;
        n_req       = r_req;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = r_idx[IDX_W-1:0];
        wr_data     = '{key: r_req.key, value: r_req.value};

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_req;
                    n_idx   = '0;
                    n_shift = 1'b0;
                    n_res   = '{status: STATUS_MISS, hit: 1'b0, found_value: '0};
                    n_state = ST_RESP;
                    if (i_in_req.func == FUNC_INSERT) begin
                        if (i_in_req.key == '0 || i_in_req.value == '0) begin
                            n_res.status = STATUS_REJECT;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end else if ((i_in_req.func == FUNC_FIND || i_in_req.func == FUNC_UPDATE)
                                 && i_in_req.key != '0) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // r_rd_data holds entry r_idx; fetch the following one
                rd_addr = idx_inc[IDX_W-1:0];
                n_idx   = idx_inc;
                if (at_end) begin
                    n_state = ST_RESP;
                    if (r_shift) begin
                        wr_en        = 1'b1;
                        wr_data      = r_carry;
                        n_count      = r_count + CNT_W'(1);
                        n_res.status = STATUS_DONE;
                    end else if (r_req.func == FUNC_INSERT) begin
                        if (full) begin
                            n_res.status = STATUS_FULL;
                        end else begin
                            wr_en        = 1'b1;
                            n_count      = r_count + CNT_W'(1);
                            n_res.status = STATUS_DONE;
                        end
                    end
                end else if (r_shift) begin
                    // ripple the displaced entry one place up
                    wr_en   = 1'b1;
                    wr_data = r_carry;
                    n_carry = r_rd_data;
                end else if (r_rd_data.key == r_req.key) begin
                    n_state   = ST_RESP;
                    n_res.hit = 1'b1;
                    case (r_req.func)
                        FUNC_INSERT: begin
                            if (r_req.overwrite_if_present) begin
                                wr_en        = 1'b1;
                                n_res.status = STATUS_DONE;
                            end else begin
                                n_res.status = STATUS_DUP;
                            end
                        end
                        FUNC_FIND: begin
                            n_res.status      = STATUS_DONE;
                            n_res.found_value = r_rd_data.value;
                        end
                        default: begin
                            wr_en        = 1'b1;
                            n_res.status = STATUS_DONE;
                        end
                    endcase
                end else if (r_rd_data.key > r_req.key) begin
                    if (r_req.func == FUNC_INSERT && !full) begin
                        wr_en   = 1'b1;
                        n_carry = r_rd_data;
                        n_shift = 1'b1;
                    end else begin
                        n_state = ST_RESP;
                        if (r_req.func == FUNC_INSERT) begin
                            n_res.status = STATUS_FULL;
                        end
                    end
                end
            end
            ST_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_shift     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_shift     <= n_shift;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_carry <= n_carry;
        r_req   <= n_req;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    `SKVT_ASSERT_NEXT(a_accept_leaves_idle, i_in_valid && !o_in_stall, r_state != ST_IDLE)
    `SKVT_ASSERT_NOW(a_count_steps_by_one, n_count != r_count, n_count == r_count + CNT_W'(1))
    `SKVT_ASSERT_NOW(a_write_within_table, wr_en, CNT_W'(wr_addr) <= r_count && r_state == ST_SCAN)

endmodule

`default_nettype wire

FILE: bench/sorted_key_value_table_tb.sv
// ---------------------------------------------------------------------------
// sorted_key_value_table_tb
// Self-checking bench for the sorted key/value table. It runs directed
// corner cases, a long result hold-off that backs the table up, and random
// insert/find/update and unused-code traffic. Results are checked against a local model.
// ---------------------------------------------------------------------------
module sorted_key_value_table_tb
    import skvt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CLK_PERIOD      = 10;
    localparam int         RESET_CYCLES    = 3;
    localparam int         RANDOM_REQUESTS = 1750;
    localparam int         BURST_REQUESTS  = 24;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam int         DRAIN_CYCLES    = 80;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         KEY_POOL_SIZE   = 96;
    localparam logic [1:0] FUNC_UNUSED     = 2'd3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    t_req req_data  = '0;
    logic res_stall = 1'b0;
    logic in_stall;
    logic res_valid;
    t_res res_data;

    // local copy of the table contents, ascending by key
    logic [KEY_W-1:0]   model_keys   [CAPACITY];
    logic [VALUE_W-1:0] model_values [CAPACITY];
    int unsigned        model_count = 0;

    t_res             expected_results [$];
    t_res             oldest_result;
    int unsigned      error_count      = 0;
    int unsigned      quiet_cycles     = 0;
    int unsigned      burst_left       = 0;
    logic             steady_sender    = 1'b0;
    logic             hold_off_pending = 1'b0;
    logic             holding_off      = 1'b0;
    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

    always #(CLK_PERIOD / 2) clk = ~clk;

    sorted_key_value_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (req_data),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out_res   (res_data)
    );

    function automatic t_req make_req(input logic [1:0] func, input logic [KEY_W-1:0] key,
                                      input logic [VALUE_W-1:0] value, input logic ow);
        t_req r;
        r.func                 = func;
        r.key                  = key;
        r.value                = value;
        r.overwrite_if_present = ow;
        return r;
    endfunction

    // applies one request to the local table and returns its result
    function automatic t_res apply_table_request(input t_req r);
        t_res        res;
        int unsigned pos;
        int unsigned j;
        logic        present;
        res.status      = STATUS_MISS;
        res.hit         = 1'b0;
        res.found_value = '0;
        pos = 0;
        while (pos < model_count && model_keys[pos] < r.key) pos++;
        present = (pos < model_count) && (r.key != '0) && (model_keys[pos] == r.key);
        case (r.func)
            FUNC_INSERT: begin
                if (r.key == '0 || r.value == '0) begin
                    res.status = STATUS_REJECT;
                end else if (present) begin
                    res.hit = 1'b1;
                    if (r.overwrite_if_present) begin
                        model_values[pos] = r.value;
                        res.status        = STATUS_DONE;
                    end else begin
                        res.status = STATUS_DUP;
                    end
                end else if (model_count >= CAPACITY) begin
                    res.status = STATUS_FULL;
                end else begin
                    // open a slot at pos by moving the larger keys up
                    for (j = model_count; j > pos; j--) begin
                        model_keys[j]   = model_keys[j-1];
                        model_values[j] = model_values[j-1];
                    end
                    model_keys[pos]   = r.key;
                    model_values[pos] = r.value;
                    model_count++;
                    res.status = STATUS_DONE;
                end
            end
            FUNC_FIND, FUNC_UPDATE: begin
                if (present) begin
                    res.hit    = 1'b1;
                    res.status = STATUS_DONE;
                    if (r.func == FUNC_FIND) begin
                        res.found_value = model_values[pos];
                    end else begin
                        model_values[pos] = r.value;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // mostly pooled keys so that finds and updates hit and the table fills
    function automatic t_req random_request();
        t_req        r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) r.func = FUNC_INSERT;
        else if (pick < 65) r.func = FUNC_FIND;
        else if (pick < 93) r.func = FUNC_UPDATE;
        else r.func = FUNC_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 80) r.key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        else if (pick < 92) r.key = $urandom;
        else if (pick < 96) r.key = '0;
        else r.key = '1;
        pick = $urandom_range(0, 99);
        if (pick < 85) r.value = $urandom;
        else if (pick < 93) r.value = '0;
        else r.value = '1;
        r.overwrite_if_present = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // call just after a rising edge; returns at the edge that takes the request or, in random bursts, after an idle gap
    task automatic send_req(input t_req r);
        req_valid <= 1'b1;
        req_data  <= r;
        do @(posedge clk); while (in_stall);
        expected_results.push_back(apply_table_request(r));
        if (!steady_sender) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) begin
                    req_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic test_directed_cases();
        send_req(make_req(FUNC_FIND,   32'd5,         32'd0,         1'b0)); // empty table
        send_req(make_req(FUNC_UPDATE, 32'd5,         32'd9,         1'b0));
        send_req(make_req(FUNC_INSERT, 32'd0,         32'd1,         1'b0)); // zero key
        send_req(make_req(FUNC_INSERT, 32'd1,         32'd0,         1'b1)); // zero value
        send_req(make_req(FUNC_INSERT, 32'd100,       32'hA5A5_0001, 1'b0));
        send_req(make_req(FUNC_INSERT, 32'd50,        32'h0000_0032, 1'b0)); // ahead of first
        send_req(make_req(FUNC_INSERT, 32'd200,       32'h0000_00C8, 1'b0));
        send_req(make_req(FUNC_INSERT, 32'd150,       32'h0000_0096, 1'b1)); // middle
        send_req(make_req(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        send_req(make_req(FUNC_INSERT, 32'd1,         32'h0000_0001, 1'b0)); // ahead again
        send_req(make_req(FUNC_INSERT, 32'd100,       32'h1234_5678, 1'b0)); // kept
        send_req(make_req(FUNC_INSERT, 32'd100,       32'h5A5A_5A5A, 1'b1)); // overwritten
        send_req(make_req(FUNC_FIND,   32'd100,       32'd0,         1'b0));
        send_req(make_req(FUNC_FIND,   32'd0,         32'd0,         1'b0));
        send_req(make_req(FUNC_UPDATE, 32'd0,         32'd7,         1'b1));
        send_req(make_req(FUNC_UPDATE, 32'd50,        32'd0,         1'b0)); // store zero
        send_req(make_req(FUNC_FIND,   32'd50,        32'hFFFF_FFFF, 1'b1));
        send_req(make_req(FUNC_FIND,   32'd75,        32'd0,         1'b0));
        send_req(make_req(FUNC_UNUSED, 32'd100,       32'd3,         1'b1));
        send_req(make_req(FUNC_UPDATE, 32'd999,       32'd3,         1'b0));
        send_req(make_req(FUNC_FIND,   32'hFFFF_FFFF, 32'd0,         1'b0));
        send_req(make_req(FUNC_FIND,   32'd1,         32'd0,         1'b0));
    endtask

    // results held off for a long stretch while requests keep coming
    task automatic test_result_hold_off();
        int unsigned n;
        req_valid <= 1'b0;
        hold_off_pending = 1'b1;
        do @(posedge clk); while (!holding_off);
        steady_sender = 1'b1;
        for (n = 0; n < BURST_REQUESTS; n++) send_req(random_request());
        steady_sender = 1'b0;
    endtask

    task automatic test_random_traffic();
        int unsigned n;
        for (n = 0; n < RANDOM_REQUESTS; n++) send_req(random_request());
    endtask

    initial begin : test_sequence
        int unsigned i;
        for (i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0001;
        key_pool[1] = '1;
        key_pool[2] = 32'h8000_0000;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_result_hold_off();
        test_random_traffic();
        req_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("sorted_key_value_table test passed");
        end else begin
            $display("sorted_key_value_table test failed");
        end
        $finish;
    end

    // receiver: stretches of random stall density, 0 % among them
    initial begin : result_stall_pattern
        int unsigned span;
        int unsigned stall_pct;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                holding_off      = 1'b1;
                res_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                holding_off = 1'b0;
            end else begin
                span      = $urandom_range(1, 40);
                stall_pct = 25 * $urandom_range(0, 3);
                repeat (span) begin
                    res_stall <= ($urandom_range(0, 99) < stall_pct);
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request pending, got %h", $time, res_data);
                error_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (res_data.status != oldest_result.status) begin
                    $display("%0t: status expected %0d, got %0d", $time,
                             oldest_result.status, res_data.status);
                    error_count++;
                end
                if (res_data.hit != oldest_result.hit) begin
                    $display("%0t: hit expected %0d, got %0d", $time,
                             oldest_result.hit, res_data.hit);
                    error_count++;
                end
                if (res_data.found_value != oldest_result.found_value) begin
                    $display("%0t: found_value expected %h, got %h", $time,
                             oldest_result.found_value, res_data.found_value);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && !in_stall) || (res_valid && !res_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("sorted_key_value_table test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/skvt_pkg.sv
hw/rtl/sorted_key_value_table.sv
bench/sorted_key_value_table_tb.sv
